// ===== sv/i2c_master_transaction_sequencer_top_defines.svh =====
// ----------------------------------------------------------------------------
// i2c master transaction sequencer assertion macros
// shared concurrent assertion wrappers, clocked on clock, reset aware
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_TOP_DEFINES_SVH

// property checked at every edge outside reset
`define I2CMTS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked at every edge, reset included
`define I2CMTS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== sv/i2cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmts_pkg
// types and codes of the i2c master transaction sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmts_pkg;

   localparam int TIMEOUT_W = 18;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 18'd200000;

   // request kinds
   localparam logic [2:0] KIND_CMD   = 3'd0;
   localparam logic [2:0] KIND_DATA  = 3'd1;
   localparam logic [2:0] KIND_EVENT = 3'd2;
   localparam logic [2:0] KIND_TICK  = 3'd3;
   localparam logic [2:0] KIND_STOP  = 3'd4;

   // command modes
   localparam logic [1:0] MODE_WR   = 2'd0;
   localparam logic [1:0] MODE_RD   = 2'd1;
   localparam logic [1:0] MODE_WRRD = 2'd2;

   // bus actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_START   = 3'd1;
   localparam logic [2:0] ACT_SEND    = 3'd2;
   localparam logic [2:0] ACT_RX_ACK  = 3'd3;
   localparam logic [2:0] ACT_RX_NACK = 3'd4;
   localparam logic [2:0] ACT_STOP    = 3'd5;

   // result codes
   localparam logic [2:0] RC_OK      = 3'd0;
   localparam logic [2:0] RC_FAIL    = 3'd1;
   localparam logic [2:0] RC_NACK    = 3'd2;
   localparam logic [2:0] RC_TIMEOUT = 3'd3;
   localparam logic [2:0] RC_INVALID = 3'd4;

   // engine status codes
   localparam logic [7:0] ST_MASK         = 8'hF8;
   localparam logic [7:0] ST_START        = 8'h08;
   localparam logic [7:0] ST_REP_START    = 8'h10;
   localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
   localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
   localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
   localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
   localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
   localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
   localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

   // register indexes
   localparam logic CSR_ENABLE  = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START    = 4'd1,
      PH_ADDR_W   = 4'd2,
      PH_DATA_REQ = 4'd3,
      PH_DATA_W   = 4'd4,
      PH_RSTART   = 4'd5,
      PH_ADDR_R   = 4'd6,
      PH_READ     = 4'd7,
      PH_STOP     = 4'd8
   } phase_type;

endpackage

`default_nettype wire

// ===== sv/i2c_master_transaction_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_top
// sequences start, address, data and stop of one i2c master transaction
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  kind, command, data, status
//  rsp_      out        rsp_valid / rsp_stall  action, bytes, done, result
//  csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
//  one request per cycle while req_stall is low; the phase logic is combinational
//  and its result, if any, shows in the output register the next cycle
//  req_stall is high only while the output register holds a result that
//  is stalled; csr_ready is always high
//  reset (synchronous) returns to idle, disabled, timeout 200000 ticks
// ----------------------------------------------------------------------------
`default_nettype none
`include "i2c_master_transaction_sequencer_top_defines.svh"

module i2c_master_transaction_sequencer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_kind,
   input  wire logic [1:0] req_mode,
   input  wire logic [6:0] req_target_address,
   input  wire logic [7:0] req_write_count,
   input  wire logic [7:0] req_read_count,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [7:0] req_bus_status,
   input  wire logic [7:0] req_read_byte,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_action,
   output logic [7:0]      rsp_send_value,
   output logic            rsp_want_data,
   output logic            rsp_read_valid,
   output logic [7:0]      rsp_read_value,
   output logic            rsp_done_res,
   output logic [2:0]      rsp_result_code,
   // configuration
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [i2cmts_pkg::TIMEOUT_W-1:0] csr_wdata
);

   localparam int TW = i2cmts_pkg::TIMEOUT_W;

   i2cmts_pkg::phase_type phase_ff, phase_in;
   logic          enable_ff;
   logic [TW-1:0] timeout_ff;
   logic [1:0]    mode_ff, mode_in;
   logic [6:0]    addr_ff, addr_in;
   logic [7:0]    writes_ff, writes_in;
   logic [7:0]    reads_ff, reads_in;
   logic [TW-1:0] wait_ff, wait_in;
   logic [2:0]    pending_ff, pending_in;
   logic          expect_ack_ff, expect_ack_in;

   logic          rsp_valid_ff;
   logic [2:0]    action_ff, action_in;
   logic [7:0]    send_ff, send_in;
   logic          want_ff, want_in;
   logic          rdv_ff, rdv_in;
   logic [7:0]    rdval_ff, rdval_in;
   logic          done_ff, done_in;
   logic [2:0]    code_ff, code_in;

   logic          req_accept;
   logic          rsp_accept;
   logic          res_gen;
   logic          cmd_bad;
   logic [7:0]    status;
   logic [TW-1:0] wait_inc;
   logic [7:0]    reads_dec;
   logic [7:0]    write_ack;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid_ff & ~rsp_stall;
   assign csr_ready  = 1'b1;

   assign status    = req_bus_status & i2cmts_pkg::ST_MASK;
   assign wait_inc  = wait_ff + TW'(1);
   assign reads_dec = (reads_ff != 8'd0) ? reads_ff - 8'd1 : 8'd0;
   assign write_ack = (phase_ff == i2cmts_pkg::PH_ADDR_W) ? i2cmts_pkg::ST_MT_SLA_ACK
                                                         : i2cmts_pkg::ST_MT_DATA_ACK;

   always_comb begin
      unique case (req_mode)
         i2cmts_pkg::MODE_WR:   cmd_bad = (req_write_count == 8'd0);
         i2cmts_pkg::MODE_RD:   cmd_bad = (req_read_count == 8'd0);
         i2cmts_pkg::MODE_WRRD: cmd_bad = (req_write_count == 8'd0) ||
                                          (req_read_count == 8'd0);
         default:               cmd_bad = 1'b1;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      writes_in     = writes_ff;
      reads_in      = reads_ff;
      wait_in       = wait_ff;
      pending_in    = pending_ff;
      expect_ack_in = expect_ack_ff;
      res_gen       = 1'b0;
      action_in     = i2cmts_pkg::ACT_NONE;
      send_in       = 8'd0;
      want_in       = 1'b0;
      rdv_in        = 1'b0;
      rdval_in      = 8'd0;
      done_in       = 1'b0;
      code_in       = i2cmts_pkg::RC_OK;

      if (req_accept) begin
         unique case (req_kind)
            i2cmts_pkg::KIND_CMD: begin
               if (phase_ff == i2cmts_pkg::PH_IDLE) begin
                  res_gen = 1'b1;
                  if (!enable_ff) begin
                     done_in = 1'b1;
                     code_in = i2cmts_pkg::RC_FAIL;
                  end else if (cmd_bad) begin
                     done_in = 1'b1;
                     code_in = i2cmts_pkg::RC_INVALID;
                  end else begin
                     mode_in    = req_mode;
                     addr_in    = req_target_address;
                     writes_in  = req_write_count;
                     reads_in   = req_read_count;
                     pending_in = i2cmts_pkg::RC_OK;
                     phase_in   = i2cmts_pkg::PH_START;
                     wait_in    = '0;
                     action_in  = i2cmts_pkg::ACT_START;
                  end
               end
            end
            i2cmts_pkg::KIND_DATA: begin
               if (phase_ff == i2cmts_pkg::PH_DATA_REQ) begin
                  res_gen   = 1'b1;
                  writes_in = (writes_ff != 8'd0) ? writes_ff - 8'd1 : 8'd0;
                  phase_in  = i2cmts_pkg::PH_DATA_W;
                  wait_in   = '0;
                  action_in = i2cmts_pkg::ACT_SEND;
                  send_in   = req_data_byte;
               end
            end
            i2cmts_pkg::KIND_EVENT: begin
               unique case (phase_ff)
                  i2cmts_pkg::PH_START, i2cmts_pkg::PH_RSTART: begin
                     res_gen = 1'b1;
                     wait_in = '0;
                     if (status != i2cmts_pkg::ST_START &&
                         status != i2cmts_pkg::ST_REP_START) begin
                        pending_in = i2cmts_pkg::RC_FAIL;
                        phase_in   = i2cmts_pkg::PH_STOP;
                        action_in  = i2cmts_pkg::ACT_STOP;
                     end else if (phase_ff == i2cmts_pkg::PH_RSTART ||
                                  mode_ff == i2cmts_pkg::MODE_RD) begin
                        phase_in  = i2cmts_pkg::PH_ADDR_R;
                        action_in = i2cmts_pkg::ACT_SEND;
                        send_in   = {addr_ff, 1'b1};
                     end else begin
                        phase_in  = i2cmts_pkg::PH_ADDR_W;
                        action_in = i2cmts_pkg::ACT_SEND;
                        send_in   = {addr_ff, 1'b0};
                     end
                  end
                  i2cmts_pkg::PH_ADDR_W, i2cmts_pkg::PH_DATA_W: begin
                     res_gen = 1'b1;
                     wait_in = '0;
                     if (status == write_ack) begin
                        if (writes_ff != 8'd0) begin
                           phase_in = i2cmts_pkg::PH_DATA_REQ;
                           want_in  = 1'b1;
                        end else if (mode_ff == i2cmts_pkg::MODE_WRRD) begin
                           phase_in  = i2cmts_pkg::PH_RSTART;
                           action_in = i2cmts_pkg::ACT_START;
                        end else begin
                           pending_in = i2cmts_pkg::RC_OK;
                           phase_in   = i2cmts_pkg::PH_STOP;
                           action_in  = i2cmts_pkg::ACT_STOP;
                        end
                     end else begin
                        phase_in  = i2cmts_pkg::PH_STOP;
                        action_in = i2cmts_pkg::ACT_STOP;
                        if (status == i2cmts_pkg::ST_MT_SLA_NACK ||
                            status == i2cmts_pkg::ST_MT_DATA_NACK) begin
                           pending_in = i2cmts_pkg::RC_NACK;
                        end else begin
                           pending_in = i2cmts_pkg::RC_FAIL;
                        end
                     end
                  end
                  i2cmts_pkg::PH_ADDR_R: begin
                     res_gen = 1'b1;
                     wait_in = '0;
                     if (status == i2cmts_pkg::ST_MR_SLA_ACK) begin
                        expect_ack_in = (reads_ff > 8'd1);
                        phase_in      = i2cmts_pkg::PH_READ;
                        action_in     = (reads_ff > 8'd1) ? i2cmts_pkg::ACT_RX_ACK
                                                          : i2cmts_pkg::ACT_RX_NACK;
                     end else begin
                        phase_in   = i2cmts_pkg::PH_STOP;
                        action_in  = i2cmts_pkg::ACT_STOP;
                        pending_in = (status == i2cmts_pkg::ST_MR_SLA_NACK) ?
                                     i2cmts_pkg::RC_NACK : i2cmts_pkg::RC_FAIL;
                     end
                  end
                  i2cmts_pkg::PH_READ: begin
                     res_gen = 1'b1;
                     wait_in = '0;
                     if (status != (expect_ack_ff ? i2cmts_pkg::ST_MR_DATA_ACK
                                                  : i2cmts_pkg::ST_MR_DATA_NACK)) begin
                        pending_in = i2cmts_pkg::RC_FAIL;
                        phase_in   = i2cmts_pkg::PH_STOP;
                        action_in  = i2cmts_pkg::ACT_STOP;
                     end else begin
                        reads_in = reads_dec;
                        rdv_in   = 1'b1;
                        rdval_in = req_read_byte;
                        if (reads_dec == 8'd0) begin
                           // last byte and stop share one result
                           pending_in = i2cmts_pkg::RC_OK;
                           phase_in   = i2cmts_pkg::PH_STOP;
                           action_in  = i2cmts_pkg::ACT_STOP;
                        end else begin
                           expect_ack_in = (reads_dec > 8'd1);
                           action_in     = (reads_dec > 8'd1) ? i2cmts_pkg::ACT_RX_ACK
                                                              : i2cmts_pkg::ACT_RX_NACK;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            i2cmts_pkg::KIND_TICK: begin
               if (phase_ff != i2cmts_pkg::PH_IDLE &&
                   phase_ff != i2cmts_pkg::PH_DATA_REQ) begin
                  wait_in = wait_inc;
                  if (wait_inc >= timeout_ff) begin
                     res_gen = 1'b1;
                     wait_in = '0;
                     if (phase_ff == i2cmts_pkg::PH_STOP) begin
                        phase_in = i2cmts_pkg::PH_IDLE;
                        done_in  = 1'b1;
                        code_in  = pending_ff;
                     end else begin
                        pending_in = i2cmts_pkg::RC_TIMEOUT;
                        phase_in   = i2cmts_pkg::PH_STOP;
                        action_in  = i2cmts_pkg::ACT_STOP;
                     end
                  end
               end
            end
            i2cmts_pkg::KIND_STOP: begin
               if (phase_ff == i2cmts_pkg::PH_STOP) begin
                  res_gen  = 1'b1;
                  wait_in  = '0;
                  phase_in = i2cmts_pkg::PH_IDLE;
                  done_in  = 1'b1;
                  code_in  = pending_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cmts_pkg::PH_IDLE;
         mode_ff       <= 2'd0;
         addr_ff       <= 7'd0;
         writes_ff     <= 8'd0;
         reads_ff      <= 8'd0;
         wait_ff       <= '0;
         pending_ff    <= i2cmts_pkg::RC_OK;
         expect_ack_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         mode_ff       <= mode_in;
         addr_ff       <= addr_in;
         writes_ff     <= writes_in;
         reads_ff      <= reads_in;
         wait_ff       <= wait_in;
         pending_ff    <= pending_in;
         expect_ack_ff <= expect_ack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         timeout_ff <= i2cmts_pkg::TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            i2cmts_pkg::CSR_ENABLE:  enable_ff  <= csr_wdata[0];
            i2cmts_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // output register, refilled in the cycle it drains
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && res_gen) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && res_gen) begin
         action_ff <= action_in;
         send_ff   <= send_in;
         want_ff   <= want_in;
         rdv_ff    <= rdv_in;
         rdval_ff  <= rdval_in;
         done_ff   <= done_in;
         code_ff   <= code_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = action_ff;
   assign rsp_send_value  = send_ff;
   assign rsp_want_data   = want_ff;
   assign rsp_read_valid  = rdv_ff;
   assign rsp_read_value  = rdval_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_result_code = code_ff;

   `I2CMTS_ASSERT(a_data_req_has_writes,
      (phase_ff == i2cmts_pkg::PH_DATA_REQ) |-> (writes_ff != 8'd0),
      "waiting for host data with no write bytes left")
   `I2CMTS_ASSERT(a_read_has_bytes,
      (phase_ff == i2cmts_pkg::PH_READ) |-> (reads_ff != 8'd0),
      "receiving with no read bytes left")
   `I2CMTS_ASSERT(a_stop_enters_stop_phase,
      (req_accept && res_gen && action_in == i2cmts_pkg::ACT_STOP) |=>
      (phase_ff == i2cmts_pkg::PH_STOP),
      "stop issued without entering the stop phase")
   `I2CMTS_ASSERT(a_done_back_to_idle,
      (req_accept && res_gen && done_in) |=> (phase_ff == i2cmts_pkg::PH_IDLE),
      "transaction ended but sequencer not idle")

endmodule

`default_nettype wire
